// File: rtl/marked_frame_receiver_crc16_core_assert.svh
// Assertion macros for the receiver RTL, clocked on clk_i and reset by rst_ni.
`ifndef MARKED_FRAME_RECEIVER_CRC16_CORE_ASSERT_SVH
`define MARKED_FRAME_RECEIVER_CRC16_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset.
`define MFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, in reset too.
`define MFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define MFR_ASSERT(lbl, prop, msg)
`define MFR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/mfr_crc16_pkg.sv
// Types, constants and CRC helpers for the marked-frame receiver.
package mfr_crc16_pkg;

  localparam int unsigned MaxFrameBytes = 64;
  localparam int unsigned MinFrameBytes = 3;
  localparam int unsigned RxCharW       = 9;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned IdxW          = 6;
  localparam int unsigned PosW          = 7;
  localparam int unsigned CrcW          = 16;
  localparam int unsigned LenW          = 7;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned ApbAddrW      = 3;
  localparam int unsigned MarkBit       = 8;

  localparam logic [CrcW-1:0] CrcPoly     = 16'hA001;
  localparam logic [LenW-1:0] LenReset    = LenW'(MaxFrameBytes);
  localparam logic [PosW-1:0] PosMaxBytes = PosW'(MaxFrameBytes);
  localparam logic [PosW-1:0] PosMinBytes = PosW'(MinFrameBytes);

  typedef enum logic [0:0] {
    RegCrcSeed     = 1'b0,
    RegFrameLength = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CrcW-1:0] crc_seed;
    logic [LenW-1:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic [RxCharW-1:0] rx_char;
    logic               line_error;
  } rx_item_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [IdxW-1:0]  byte_index;
    logic             frame_done;
    logic             crc_ok;
  } res_item_t;

  // Reflected CRC-16 update by one byte, bit at a time.
  function automatic logic [CrcW-1:0] crc_fold(logic [CrcW-1:0] crc, logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int i = 0; i < ByteW; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Frame length clamped to the supported range.
  function automatic logic [PosW-1:0] eff_len(logic [LenW-1:0] n);
    logic [PosW-1:0] l;
    l = PosW'(n);
    if (l < PosMinBytes) begin
      l = PosMinBytes;
    end else if (l > PosMaxBytes) begin
      l = PosMaxBytes;
    end
    return l;
  endfunction

endpackage

// File: rtl/mfr_stream_if.sv
// Valid/ready stream interfaces for received characters and result bytes.
interface mfr_rx_if;
  import mfr_crc16_pkg::*;

  logic               valid;
  logic               ready;
  logic [RxCharW-1:0] rx_char;
  logic               line_error;

  modport source (output valid, output rx_char, output line_error, input ready);
  modport sink   (input valid, input rx_char, input line_error, output ready);
endinterface

interface mfr_res_if;
  import mfr_crc16_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic [IdxW-1:0]  byte_index;
  logic             frame_done;
  logic             crc_ok;

  modport source (output valid, output data_byte, output byte_index, output frame_done,
                  output crc_ok, input ready);
  modport sink   (input valid, input data_byte, input byte_index, input frame_done,
                  input crc_ok, output ready);
endinterface

// File: rtl/mfr_cfg_regs.sv
// APB configuration registers: CRC seed and frame length.
module mfr_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mfr_crc16_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mfr_crc16_pkg::ApbDataW-1:0]  pwdata,
  output logic [mfr_crc16_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready,
  output mfr_crc16_pkg::cfg_t                 cfg_o
);
  import mfr_crc16_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  // Registers sit on 4-byte boundaries; low address bits are ignored.
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegCrcSeed:     cfg_d.crc_seed     = pwdata[CrcW-1:0];
        RegFrameLength: cfg_d.frame_length = pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegCrcSeed:     prdata = {{(ApbDataW-CrcW){1'b0}}, cfg_q.crc_seed};
      RegFrameLength: prdata = {{(ApbDataW-LenW){1'b0}}, cfg_q.frame_length};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_seed     <= '0;
      cfg_q.frame_length <= LenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/mfr_in_reg.sv
// Input register: captures one received character per cycle while the frame processor takes the held one.
module mfr_in_reg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  mfr_rx_if.sink                   rx_i,
  input  logic                     take_i,
  output logic                     valid_o,
  output mfr_crc16_pkg::rx_item_t  item_o
);
  import mfr_crc16_pkg::*;

  logic     valid_q, valid_d;
  rx_item_t item_q, item_d;
  logic     load;

  // Refill in the same cycle the held request moves on.
  assign rx_i.ready = !valid_q || take_i;
  assign load       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d         = 1'b1;
      item_d.rx_char    = rx_i.rx_char;
      item_d.line_error = rx_i.line_error;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/mfr_frame_proc.sv
// Frame tracking, CRC update and result register.
`include "marked_frame_receiver_crc16_core_assert.svh"

module mfr_frame_proc (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mfr_crc16_pkg::cfg_t      cfg_i,
  input  logic                     in_valid_i,
  input  mfr_crc16_pkg::rx_item_t  item_i,
  output logic                     take_o,
  mfr_res_if.source                res_o
);
  import mfr_crc16_pkg::*;

  logic [PosW-1:0] pos_q, pos_d, pos_next;
  logic [CrcW-1:0] crc_q, crc_d, crc_new;
  logic            res_valid_q, res_valid_d;
  res_item_t       res_q, res_d;
  logic            fire, produce, mark, done;

  assign mark = item_i.rx_char[MarkBit];

  // A held request moves once the result register is free or being emptied.
  assign fire   = in_valid_i && (!res_valid_q || res_o.ready);
  assign take_o = fire;

  always_comb begin
    produce  = !item_i.line_error && (mark || (pos_q != '0));
    crc_new  = crc_fold(mark ? cfg_i.crc_seed : crc_q, item_i.rx_char[ByteW-1:0]);
    pos_next = mark ? PosW'(1) : pos_q + PosW'(1);
    done     = produce && (pos_next >= eff_len(cfg_i.frame_length));

    res_d.data_byte  = item_i.rx_char[ByteW-1:0];
    res_d.byte_index = mark ? '0 : pos_q[IdxW-1:0];
    res_d.frame_done = done;
    res_d.crc_ok     = done && (crc_new == '0);

    pos_d = pos_q;
    crc_d = crc_q;
    if (fire && produce) begin
      crc_d = crc_new;
      pos_d = done ? '0 : pos_next;
    end

    res_valid_d = res_valid_q;
    if (fire) begin
      res_valid_d = produce;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && produce) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.data_byte  = res_q.data_byte;
  assign res_o.byte_index = res_q.byte_index;
  assign res_o.frame_done = res_q.frame_done;
  assign res_o.crc_ok     = res_q.crc_ok;

  `MFR_ASSERT_ALWAYS(a_pos_in_range, !rst_ni || (pos_q < PosMaxBytes), "frame position past maximum")
  `MFR_ASSERT(a_ok_needs_done, res_valid_q |-> (!res_q.crc_ok || res_q.frame_done), "crc_ok without frame_done")
  `MFR_ASSERT(a_done_closes_frame, (fire && produce && done) |=> (pos_q == '0), "frame left open after last byte")
  `MFR_ASSERT(a_mark_index_zero, (fire && produce && mark) |=> (res_valid_q && (res_q.byte_index == '0)), "start byte not at index zero")
  `MFR_ASSERT(a_drop_keeps_state, (fire && !produce) |=> ($stable(pos_q) && $stable(crc_q)), "dropped character changed frame state")

endmodule

// File: rtl/marked_frame_receiver_crc16_core.sv
// Marked-frame receiver with CRC-16 check: top level.
// Path: an accepted request waits in the input register and moves into the result register
// once that register is free or being emptied; its result is then offered on res_o.
// Throughput: one character per cycle while res_o is ready; a single CRC fold lies between the registers.
// A dropped character (line error, or unmarked outside a frame) yields no result.
// Reset (rst_ni low, asynchronous) closes any frame, clears the CRC and empties both registers;
// crc_seed resets to 0 and frame_length to 64. No clearing pass is needed.
module marked_frame_receiver_crc16_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mfr_rx_if.sink                              rx_i,
  mfr_res_if.source                           res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mfr_crc16_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mfr_crc16_pkg::ApbDataW-1:0]  pwdata,
  output logic [mfr_crc16_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready
);
  import mfr_crc16_pkg::*;

  cfg_t     cfg;
  rx_item_t item;
  logic     item_valid;
  logic     take;

  mfr_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mfr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  mfr_frame_proc u_frame_proc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (item_valid),
    .item_i     (item),
    .take_o     (take),
    .res_o      (res_o)
  );

endmodule
